// ===== sv/lssh_pkg.sv =====
// Shared types, widths and helpers for the log-spaced sample history.
// No dependencies; imported by every module of the block.
`default_nettype none

package lssh_pkg;

  localparam int STAMP_W  = 32;
  localparam int SAMPLE_W = 47;
  localparam int VALUE_W  = 48;
  localparam int BASE_W   = 16;
  localparam int IDX_W    = 4;

  localparam logic [BASE_W-1:0] BASE_RESET = 16'd225;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [SAMPLE_W-1:0] sample;
  } entry_t;

  // True when now - stamp, taken as a signed difference, exceeds limit.
  function automatic logic too_old(input logic [STAMP_W-1:0] now,
                                   input logic [STAMP_W-1:0] stamp,
                                   input logic [STAMP_W-1:0] limit);
    logic [STAMP_W:0] diff;
    diff = {1'b0, now} - {1'b0, stamp};
    return !diff[STAMP_W] && (diff[STAMP_W-1:0] > limit);
  endfunction

endpackage

`default_nettype wire

// ===== sv/lssh_update.sv =====
// Next-history logic: front insert, drop/pad and pairwise ageing of the slots.
// Depends on lssh_pkg.
`default_nettype none

module lssh_update #(
  parameter int HISTORY_SLOTS = 10,
  parameter int CNT_W         = 4
) (
  input  wire logic                         insert,
  input  wire logic [lssh_pkg::STAMP_W-1:0]  now,
  input  wire logic [lssh_pkg::SAMPLE_W-1:0] value,
  input  wire logic [lssh_pkg::BASE_W-1:0]   base,
  input  wire logic [CNT_W-1:0]              count_i,
  input  lssh_pkg::entry_t                   slot_i [HISTORY_SLOTS],
  output lssh_pkg::entry_t                   slot_o [HISTORY_SLOTS],
  output logic [CNT_W-1:0]                   count_o
);
  import lssh_pkg::*;

  localparam int TOP_STEP = ((HISTORY_SLOTS - 2) / 2) * 2;
  localparam int STEPS    = TOP_STEP / 2;

  entry_t fresh;
  entry_t pad_entry;
  entry_t shifted [HISTORY_SLOTS];
  entry_t padded  [HISTORY_SLOTS];
  entry_t aged    [HISTORY_SLOTS];
  logic   full_path;
  logic   drop_third;

  assign fresh      = '{stamp: now, sample: value};
  assign full_path  = (count_i >= CNT_W'(2));
  // old slot 1 older than base: drop it, keeping old slot 0 as slot 1
  assign drop_third = too_old(now, slot_i[1].stamp, STAMP_W'(base));
  assign pad_entry  = drop_third ? slot_i[0] : slot_i[1];

  always_comb begin
    shifted[0] = fresh;
    padded[0]  = fresh;
    padded[1]  = pad_entry;
    for (int k = 1; k < HISTORY_SLOTS; k++) begin
      shifted[k] = slot_i[k-1];
    end
    for (int k = 2; k < HISTORY_SLOTS; k++) begin
      padded[k] = (CNT_W'(k) < count_i) ? slot_i[k] : pad_entry;
    end
  end

  // Each pair step reads only slots below those touched by the older steps,
  // so all steps work side by side on the padded history.
  assign aged[0] = padded[0];
  assign aged[1] = padded[1];

  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [STAMP_W-1:0] scaled;
    logic [STAMP_W-1:0] limit;
    logic               stale;
    entry_t             mid_mv;
    entry_t             old_mv;

    assign scaled = STAMP_W'(base) << s;
    assign limit  = scaled + (scaled >> 1);
    assign stale  = too_old(now, padded[2*s+1].stamp, limit);
    assign old_mv = stale ? padded[2*s]   : padded[2*s+1];
    assign mid_mv = stale ? padded[2*s-1] : padded[2*s];

    assign aged[2*s+1] = old_mv;
    assign aged[2*s]   = ((old_mv.stamp == mid_mv.stamp) &&
                          (mid_mv.stamp != padded[2*s-1].stamp)) ?
                         padded[2*s-1] : mid_mv;
  end

  if (TOP_STEP + 2 < HISTORY_SLOTS) begin : g_odd_tail
    assign aged[HISTORY_SLOTS-1] = padded[HISTORY_SLOTS-1];
  end

  always_comb begin
    for (int k = 0; k < HISTORY_SLOTS; k++) begin
      if (!insert) begin
        slot_o[k] = slot_i[k];
      end else if (full_path) begin
        slot_o[k] = aged[k];
      end else begin
        slot_o[k] = shifted[k];
      end
    end
    if (!insert) begin
      count_o = count_i;
    end else if (full_path) begin
      count_o = CNT_W'(HISTORY_SLOTS);
    end else begin
      count_o = count_i + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/lssh_read.sv =====
// Slot selection for the result word; empty slots read as zero.
// Depends on lssh_pkg.
`default_nettype none

module lssh_read #(
  parameter int HISTORY_SLOTS = 10,
  parameter int CNT_W         = 4
) (
  input  lssh_pkg::entry_t                   slot_i [HISTORY_SLOTS],
  input  wire logic [CNT_W-1:0]              count_i,
  input  wire logic [lssh_pkg::IDX_W-1:0]    idx,
  output logic [lssh_pkg::STAMP_W-1:0]       stamp_o,
  output logic [lssh_pkg::SAMPLE_W-1:0]      sample_o
);
  import lssh_pkg::*;

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  logic hit;

  assign hit = (CMP_W'(idx) < CMP_W'(count_i));

  always_comb begin
    stamp_o  = '0;
    sample_o = '0;
    for (int k = 0; k < HISTORY_SLOTS; k++) begin
      if (hit && (CMP_W'(idx) == CMP_W'(k))) begin
        stamp_o  = slot_i[k].stamp;
        sample_o = slot_i[k].sample;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/log_spaced_sample_history.sv =====
// Log-spaced sample history, top level.
// Depends on lssh_pkg, lssh_update and lssh_read.
//
// Use: the input channel (in_valid / in_stall) carries one request word:
// req_type, now_time, space_kb and read_index. An insert with a positive
// space_kb goes to the front of the history; the history then drops and pads
// slots and ages out older pairs so slot ages stay roughly log spaced. Every
// word, insert or read-only, yields exactly one result word on the output
// channel (out_valid / out_stall): accepted flag, slot count after the word,
// and the stamp and value of slot read_index (zero when that slot is empty).
// cfg_wr_en / cfg_wr_data write base_interval; write it only while idle.
//
// Timing: an accepted word sits in the input register; when the result
// register is free, the history is updated and the result register loaded,
// which raises out_valid. One word per cycle is sustained while the receiver
// does not stall: the whole history update is a single combinational pass
// between those two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) empties the history, drops any word in
// flight and restores base_interval to 225.
`default_nettype none

module log_spaced_sample_history #(
  parameter int HISTORY_SLOTS = 10
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [lssh_pkg::BASE_W-1:0]            cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_req_type,
  input  wire logic [lssh_pkg::STAMP_W-1:0]           in_now_time,
  input  wire logic signed [lssh_pkg::VALUE_W-1:0]    in_space_kb,
  input  wire logic [lssh_pkg::IDX_W-1:0]             in_read_index,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_accepted,
  output logic [$clog2(HISTORY_SLOTS+1)-1:0]          out_entry_count,
  output logic [lssh_pkg::STAMP_W-1:0]                out_entry_time,
  output logic [lssh_pkg::SAMPLE_W-1:0]               out_entry_value
);
  import lssh_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_SLOTS + 1);

  // input register
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_req_r;
  logic [STAMP_W-1:0]        s1_now_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic [IDX_W-1:0]          s1_idx_r;

  // history and configuration
  logic [BASE_W-1:0]         base_r;
  entry_t                    slot_r   [HISTORY_SLOTS];
  entry_t                    slot_nxt [HISTORY_SLOTS];
  logic [CNT_W-1:0]          count_r, count_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_accepted_r;
  logic [CNT_W-1:0]          out_count_r;
  logic [STAMP_W-1:0]        out_time_r, out_time_nxt;
  logic [SAMPLE_W-1:0]       out_value_r, out_value_nxt;

  logic                      in_take;
  logic                      out_free;
  logic                      s1_adv;
  logic                      do_insert;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // store only an insert with a strictly positive value
  assign do_insert = s1_valid_r && (s1_req_r == REQ_INSERT) &&
                     !s1_value_r[VALUE_W-1] && (s1_value_r != '0);

  lssh_update #(
    .HISTORY_SLOTS (HISTORY_SLOTS),
    .CNT_W         (CNT_W)
  ) u_update (
    .insert  (do_insert),
    .now     (s1_now_r),
    .value   (s1_value_r[SAMPLE_W-1:0]),
    .base    (base_r),
    .count_i (count_r),
    .slot_i  (slot_r),
    .slot_o  (slot_nxt),
    .count_o (count_nxt)
  );

  // read from the updated history so the result reflects this word
  lssh_read #(
    .HISTORY_SLOTS (HISTORY_SLOTS),
    .CNT_W         (CNT_W)
  ) u_read (
    .slot_i   (slot_nxt),
    .count_i  (count_nxt),
    .idx      (s1_idx_r),
    .stamp_o  (out_time_nxt),
    .sample_o (out_value_nxt)
  );

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      base_r      <= BASE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // payload: input fields load on a take; history and result hold unless the stage advances
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r   <= in_req_type;
      s1_now_r   <= in_now_time;
      s1_value_r <= in_space_kb;
      s1_idx_r   <= in_read_index;
    end
    if (s1_adv) begin
      slot_r         <= slot_nxt;
      out_accepted_r <= do_insert;
      out_count_r    <= count_nxt;
      out_time_r     <= out_time_nxt;
      out_value_r    <= out_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_entry_count = out_count_r;
  assign out_entry_time  = out_time_r;
  assign out_entry_value = out_value_r;

endmodule

`default_nettype wire

// ===== sv/lssh_checker.sv =====
// Port-level checks for the log-spaced sample history, bound to the top level.
// Depends on lssh_pkg and log_spaced_sample_history.
`default_nettype none

module lssh_checker #(
  parameter int HISTORY_SLOTS = 10
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic                                out_accepted,
  input wire logic [$clog2(HISTORY_SLOTS+1)-1:0]  out_entry_count,
  input wire logic [lssh_pkg::STAMP_W-1:0]        out_entry_time,
  input wire logic [lssh_pkg::SAMPLE_W-1:0]       out_entry_value
);
  import lssh_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_SLOTS + 1);

  // no result word survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a stored insert always leaves at least one slot
  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_entry_count != '0)
    else $error("accepted insert with empty history");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(HISTORY_SLOTS))
    else $error("slot count beyond history depth");

  // an empty history reads as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0 |->
      out_entry_time == '0 && out_entry_value == '0)
    else $error("empty history returned a non-zero slot");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_count) &&
      $stable(out_entry_time) && $stable(out_entry_value))
    else $error("stalled result word changed");

endmodule

bind log_spaced_sample_history lssh_checker #(
  .HISTORY_SLOTS (HISTORY_SLOTS)
) u_lssh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_accepted    (out_accepted),
  .out_entry_count (out_entry_count),
  .out_entry_time  (out_entry_time),
  .out_entry_value (out_entry_value)
);

`default_nettype wire
